FILE: design/lkcr_pkg.sv
// ============================================================================
// lkcr_pkg
// Shared types, constants and arithmetic helpers for the Lehmer-keyed
// character rotation cipher.
// ============================================================================
package lkcr_pkg;

    // Generator and symbol constants.
    localparam int unsigned GEN_W      = 17;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned LEHMER_MUL = 75;
    localparam int unsigned LEHMER_MOD = 65537;
    localparam int unsigned LOW16_MASK = 65535;
    localparam int unsigned PRINT_BASE = 32;
    localparam int unsigned PRINT_SPAN = 96;
    localparam int unsigned PROD_W     = GEN_W + 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_SEED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd1;

    // One configuration write as seen by the front and back parts.
    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [GEN_W-1:0]     data;
    } t_cfg_write;

    // One classified character waiting in the queue.
    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic [GEN_W-1:0]  key;
        logic              pass;
    } t_entry;

    // Queue occupancy status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Advance the generator: state times 75, folded modulo 65537 using
    // the identity that 2^16 is congruent to minus one.
    function automatic logic [GEN_W-1:0] advance_gen(input logic [GEN_W-1:0] s);
        logic [PROD_W-1:0] prod;
        logic [GEN_W-1:0]  lo;
        logic [GEN_W-1:0]  hi;
        logic [GEN_W-1:0]  res;
        prod = PROD_W'(s) * PROD_W'(LEHMER_MUL);
        lo   = GEN_W'(prod & PROD_W'(LOW16_MASK));
        hi   = GEN_W'(prod >> 16);
        if (lo >= hi) begin
            res = lo - hi;
        end else begin
            res = lo + GEN_W'(LEHMER_MOD) - hi;
        end
        return res;
    endfunction

    // Key modulo 96: the low five bits stand, and the remaining bits are
    // reduced modulo three by summing base-four digits.
    function automatic logic [CHAR_W-1:0] key_mod96(input logic [GEN_W-1:0] key);
        logic [4:0] acc;
        logic [1:0] rem;
        acc = '0;
        for (int i = 0; i < 6; i++) begin
            acc = acc + 5'(key[5 + 2*i +: 2]);
        end
        if (acc >= 5'd12) acc = acc - 5'd12;
        if (acc >= 5'd6)  acc = acc - 5'd6;
        if (acc >= 5'd3)  acc = acc - 5'd3;
        rem = acc[1:0];
        return {rem, key[4:0]};
    endfunction

endpackage

FILE: design/lkcr_front.sv
// ============================================================================
// lkcr_front
// Accepts characters, advances the Lehmer generator for each one and pushes
// the character, its key and a pass-through flag into the queue.
// ============================================================================
module lkcr_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lkcr_pkg::CHAR_W-1:0] i_char_in,
    output logic                      o_ready,
    input  lkcr_pkg::t_cfg_write      i_cfg,
    input  lkcr_pkg::t_q_status       i_q_status,
    output logic                      o_push,
    output lkcr_pkg::t_entry          o_entry
);

    logic [lkcr_pkg::GEN_W-1:0] r_gen;
    logic [lkcr_pkg::GEN_W-1:0] n_gen;

    // A request is taken whenever the queue has room.
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // Next generator value and the classified entry.
    assign n_gen = lkcr_pkg::advance_gen(r_gen);

    always_comb begin
        o_entry.char_in = i_char_in;
        o_entry.key     = n_gen;
        o_entry.pass    = (i_char_in < lkcr_pkg::CHAR_W'(lkcr_pkg::PRINT_BASE));
    end

    // Generator state: loaded by a seed write, else advanced on every taken request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= lkcr_pkg::GEN_W'(1);
        end else if (i_cfg.we && i_cfg.index == lkcr_pkg::CFG_START_SEED) begin
            r_gen <= i_cfg.data;
        end else if (o_push) begin
            r_gen <= n_gen;
        end
    end

endmodule

FILE: design/lkcr_queue.sv
// ============================================================================
// lkcr_queue
// Two-entry queue that decouples the front part from the back part.
// ============================================================================
module lkcr_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lkcr_pkg::t_entry    i_entry,
    input  logic                i_pop,
    output lkcr_pkg::t_entry    o_head,
    output lkcr_pkg::t_q_status o_status
);

    lkcr_pkg::t_entry r_slot [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;

    assign o_head          = r_slot[r_rd_ptr];
    assign o_status.full   = (r_count == 2'd2);
    assign o_status.empty  = (r_count == 2'd0);

    // Slot storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

FILE: design/lkcr_back.sv
// ============================================================================
// lkcr_back
// Takes entries from the queue, rotates printable characters by the key
// modulo 96 and holds the result in the output register.
// ============================================================================
module lkcr_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lkcr_pkg::t_cfg_write        i_cfg,
    input  lkcr_pkg::t_entry            i_head,
    input  lkcr_pkg::t_q_status         i_q_status,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lkcr_pkg::CHAR_W-1:0] o_char_out
);

    logic                        r_decrypt;
    logic                        r_valid;
    logic [lkcr_pkg::CHAR_W-1:0] r_char_out;
    logic [lkcr_pkg::CHAR_W-1:0] n_char_out;
    logic [lkcr_pkg::CHAR_W-1:0] key_mod;
    logic [lkcr_pkg::CHAR_W-1:0] offset;
    logic [7:0]                  sum;

    assign o_valid    = r_valid;
    assign o_char_out = r_char_out;

    // Take the next entry when the output register is free or being drained.
    assign o_pop = !i_q_status.empty && (!r_valid || i_ready);

    // Rotation within the printable range.
    always_comb begin
        key_mod = lkcr_pkg::key_mod96(i_head.key);
        offset  = i_head.char_in - lkcr_pkg::CHAR_W'(lkcr_pkg::PRINT_BASE);
        if (r_decrypt) begin
            sum = 8'(offset) + 8'(lkcr_pkg::PRINT_SPAN) - 8'(key_mod);
        end else begin
            sum = 8'(offset) + 8'(key_mod);
        end
        if (sum >= 8'(lkcr_pkg::PRINT_SPAN)) begin
            sum = sum - 8'(lkcr_pkg::PRINT_SPAN);
        end
        if (i_head.pass) begin
            n_char_out = i_head.char_in;
        end else begin
            n_char_out = 7'(sum) + lkcr_pkg::CHAR_W'(lkcr_pkg::PRINT_BASE);
        end
    end

    // Direction register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
        end else if (i_cfg.we && i_cfg.index == lkcr_pkg::CFG_DECRYPT_MODE) begin
            r_decrypt <= i_cfg.data[0];
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_char_out <= n_char_out;
        end
    end

endmodule

FILE: design/lehmer_keyed_char_rotation_cipher_unit.sv
// ============================================================================
// lehmer_keyed_char_rotation_cipher_unit
// Stream cipher that rotates printable characters by a Lehmer key.
// ============================================================================
// Usage:
// Characters arrive on the i_valid / o_ready request channel and results
// leave on the o_valid / i_ready channel, one result per request.
// Each request advances a Lehmer generator (times 75 modulo 65537);
// characters below 32 pass unchanged, others rotate within 32..127 by the
// new state modulo 96, forward to encrypt and backward to decrypt.
// A taken request is written into a queue slot and then into the output
// register, which drives o_valid. Throughput is one request per cycle while
// i_ready stays high, with the front part updating the generator per request.
// A two-entry queue sits between the front and the output register, so
// the block keeps taking requests until the queue fills while the receiver
// stalls; o_ready drops only when both queue slots are occupied.
// Configuration: i_cfg_we writes register i_cfg_index (0 start seed, which
// also loads the generator, 1 decrypt mode); other indexes are ignored.
// Reset sets the generator to 1, selects encrypt and empties the queue
// and the output register.
// ============================================================================
module lehmer_keyed_char_rotation_cipher_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lkcr_pkg::CHAR_W-1:0]    i_char_in,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lkcr_pkg::CHAR_W-1:0]    o_char_out,
    input  logic                           i_cfg_we,
    input  logic [lkcr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lkcr_pkg::GEN_W-1:0]     i_cfg_data
);

    lkcr_pkg::t_cfg_write cfg;
    lkcr_pkg::t_entry     push_entry;
    lkcr_pkg::t_entry     head_entry;
    lkcr_pkg::t_q_status  q_status;
    logic                 push;
    logic                 pop;

    always_comb begin
        cfg.we    = i_cfg_we;
        cfg.index = i_cfg_index;
        cfg.data  = i_cfg_data;
    end

    // Front part: accept and key each character.
    lkcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_char_in  (i_char_in),
        .o_ready    (o_ready),
        .i_cfg      (cfg),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // Queue between the two parts.
    lkcr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head_entry),
        .o_status (q_status)
    );

    // Back part: rotate and deliver.
    lkcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_head     (head_entry),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_out (o_char_out)
    );

    // A request that was taken leaves the queue non-empty.
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !q_status.empty)
        else $error("queue empty right after an accepted request");

    // The front stops taking requests whenever the queue is full.
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> !o_ready)
        else $error("request taken while queue full");

    // Reset leaves no result and no queued entry.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && q_status.empty))
        else $error("state not cleared by reset");

endmodule

FILE: tb/tb_lehmer_keyed_char_rotation_cipher_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_lehmer_keyed_char_rotation_cipher_unit
// Self-checking bench for the Lehmer-keyed character rotation cipher. A
// queue-fed driver pushes character requests, and a monitor keeps its own
// generator and mode copy, predicts each output character, and matches
// results in order. Directed requests cover the character and seed
// extremes, and random batches then run under varied back-pressure.
// ============================================================================
module tb_lehmer_keyed_char_rotation_cipher_unit;

    // Indexes outside the register map; writes to them must be dropped.
    localparam logic [lkcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [lkcr_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // Back-pressure profiles used by the random batches.
    typedef enum int {
        PACE_FULL_RATE,
        PACE_SENDER_SLOW,
        PACE_RECEIVER_SLOW,
        PACE_BOTH_SLOW
    } t_pace;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_valid = 1'b0;
    logic                           o_ready;
    logic [lkcr_pkg::CHAR_W-1:0]    i_char_in = '0;
    logic                           o_valid;
    logic                           i_ready = 1'b0;
    logic [lkcr_pkg::CHAR_W-1:0]    o_char_out;
    logic                           i_cfg_we = 1'b0;
    logic [lkcr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [lkcr_pkg::GEN_W-1:0]     i_cfg_data = '0;

    // Characters waiting to be sent and output characters still owed.
    logic [lkcr_pkg::CHAR_W-1:0] char_send_q[$];
    logic [lkcr_pkg::CHAR_W-1:0] char_expected_q[$];

    // Local copy of the generator and the rotation direction.
    logic [lkcr_pkg::GEN_W-1:0]  gen_state_copy = 17'd1;
    logic                        decrypt_copy = 1'b0;

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       queued_count = 0;
    int unsigned       result_count = 0;
    int unsigned       error_count = 0;
    logic              req_taken = 1'b0;

    lehmer_keyed_char_rotation_cipher_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_in   (i_char_in),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_char_out  (o_char_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running 2 ns clock.
    always #1 i_clk = ~i_clk;

    // One generator step: multiply by 75 and fold modulo 65537, using the
    // fact that 2^16 is congruent to minus one.
    function automatic logic [lkcr_pkg::GEN_W-1:0] lehmer_next(
            input logic [lkcr_pkg::GEN_W-1:0] s);
        int unsigned prod;
        int unsigned lo;
        int unsigned hi;
        prod = 32'(s);
        prod = prod * lkcr_pkg::LEHMER_MUL;
        lo   = prod & lkcr_pkg::LOW16_MASK;
        hi   = prod >> 16;
        if (lo >= hi) begin
            return lkcr_pkg::GEN_W'(lo - hi);
        end
        return lkcr_pkg::GEN_W'(lo + lkcr_pkg::LEHMER_MOD - hi);
    endfunction

    // Rotate a printable character by the key within 32..127; control
    // characters are returned untouched.
    function automatic logic [lkcr_pkg::CHAR_W-1:0] predict_symbol(
            input logic [lkcr_pkg::CHAR_W-1:0] ch,
            input logic [lkcr_pkg::GEN_W-1:0]  key,
            input logic                        backward);
        int unsigned off;
        int unsigned shift;
        if (ch < lkcr_pkg::PRINT_BASE) begin
            return ch;
        end
        off   = ch - lkcr_pkg::PRINT_BASE;
        shift = key % lkcr_pkg::PRINT_SPAN;
        if (backward) begin
            off = (off + lkcr_pkg::PRINT_SPAN - shift) % lkcr_pkg::PRINT_SPAN;
        end else begin
            off = (off + shift) % lkcr_pkg::PRINT_SPAN;
        end
        return lkcr_pkg::CHAR_W'(off + lkcr_pkg::PRINT_BASE);
    endfunction

    // Request driver: holds a pending request until it is taken, then
    // either presents the next character or idles.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || req_taken) begin
            if (char_send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid   <= 1'b1;
                i_char_in <= char_send_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: tracks register writes, predicts each taken request and
    // checks every delivered result against the oldest prediction.
    always @(posedge i_clk) begin
        logic [lkcr_pkg::CHAR_W-1:0] want;
        if (i_rst_n) begin
            req_taken <= i_valid && o_ready;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    lkcr_pkg::CFG_START_SEED: begin
                        gen_state_copy = i_cfg_data;
                    end
                    lkcr_pkg::CFG_DECRYPT_MODE: begin
                        decrypt_copy = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (o_valid && i_ready) begin
                result_count <= result_count + 1;
                if (char_expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%02h",
                             $time, o_char_out);
                    error_count++;
                end else begin
                    want = char_expected_q.pop_front();
                    if (o_char_out !== want) begin
                        $display("%0t: char_out mismatch, expected 0x%02h, actual 0x%02h",
                                 $time, want, o_char_out);
                        error_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                gen_state_copy = lehmer_next(gen_state_copy);
                char_expected_q.push_back(predict_symbol(i_char_in, gen_state_copy,
                                                         decrypt_copy));
            end
        end
    end

    // Write one configuration register.
    task automatic write_reg(input logic [lkcr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lkcr_pkg::GEN_W-1:0]     data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Select the back-pressure profile for the next batch.
    task automatic set_pace(input t_pace pace);
        @(posedge i_clk);
        case (pace)
            PACE_FULL_RATE: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            PACE_SENDER_SLOW: begin
                send_idle_pct  = 77;
                recv_stall_pct = 0;
            end
            PACE_RECEIVER_SLOW: begin
                send_idle_pct  = 0;
                recv_stall_pct = 77;
            end
            default: begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
        endcase
    endtask

    task automatic queue_char(input logic [lkcr_pkg::CHAR_W-1:0] ch);
        char_send_q.push_back(ch);
        queued_count++;
    endtask

    // Wait until every queued character has produced its result, then let
    // the output register settle before touching the registers.
    task automatic wait_drained();
        while (result_count != queued_count) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    // Stimulus sequence.
    initial begin
        t_pace pace;
        logic [lkcr_pkg::GEN_W-1:0] seed;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: seed of one, encrypting, full rate.
        set_pace(PACE_FULL_RATE);
        queue_char(7'd0);
        queue_char(7'd31);
        queue_char(7'd32);
        queue_char(7'd33);
        queue_char(7'd127);
        queue_char(7'd126);
        queue_char(7'd96);
        queue_char(7'h55);
        queue_char(7'h2A);
        queue_char(7'd1);
        queue_char(7'h7F);
        wait_drained();

        // Writes to unmapped indexes must leave both registers alone.
        write_reg(CFG_SPARE_2, 17'h1FFFF);
        write_reg(CFG_SPARE_3, 17'h1FFFF);
        write_reg(lkcr_pkg::CFG_START_SEED, 17'd65536);
        write_reg(lkcr_pkg::CFG_DECRYPT_MODE, 17'd1);
        set_pace(PACE_BOTH_SLOW);
        queue_char(7'd32);
        queue_char(7'd127);
        queue_char(7'd0);
        queue_char(7'd31);
        queue_char(7'h2A);
        queue_char(7'h55);
        wait_drained();

        // A zero seed freezes the generator, so nothing is rotated.
        write_reg(lkcr_pkg::CFG_START_SEED, 17'd0);
        write_reg(lkcr_pkg::CFG_DECRYPT_MODE, 17'd0);
        set_pace(PACE_RECEIVER_SLOW);
        queue_char(7'd32);
        queue_char(7'd127);
        queue_char(7'd80);
        queue_char(7'd5);
        wait_drained();

        // A seed above the modulus is folded on the first step.
        write_reg(lkcr_pkg::CFG_START_SEED, 17'h1FFFF);
        set_pace(PACE_SENDER_SLOW);
        queue_char(7'd32);
        queue_char(7'd127);
        queue_char(7'd64);
        queue_char(7'd16);
        wait_drained();

        // Random batches across every pace, each with a random direction.
        for (int b = 0; b < 8; b++) begin
            pace = t_pace'(b % 4);
            if (b == 3) begin
                seed = 17'd65536;
            end else if (b == 6) begin
                seed = lkcr_pkg::GEN_W'($urandom_range(65537, 131071));
            end else begin
                seed = lkcr_pkg::GEN_W'($urandom_range(1, 65536));
            end
            // Sometimes keep the running generator instead of reseeding.
            if (b == 3 || b == 6 || $urandom_range(3) != 0) begin
                write_reg(lkcr_pkg::CFG_START_SEED, seed);
            end
            write_reg(lkcr_pkg::CFG_DECRYPT_MODE, lkcr_pkg::GEN_W'($urandom_range(1)));
            set_pace(pace);
            for (int n = 0; n < 56; n++) begin
                queue_char(lkcr_pkg::CHAR_W'($urandom_range(127)));
            end
            wait_drained();
        end

        repeat (4) @(negedge i_clk);
        if (char_expected_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     char_expected_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_lehmer_keyed_char_rotation_cipher_unit passed");
        end else begin
            $display("tb_lehmer_keyed_char_rotation_cipher_unit failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #1000000;
        $display("tb_lehmer_keyed_char_rotation_cipher_unit failed");
        $finish;
    end

endmodule

FILE: files.f
design/lkcr_pkg.sv
design/lkcr_front.sv
design/lkcr_queue.sv
design/lkcr_back.sv
design/lehmer_keyed_char_rotation_cipher_unit.sv
tb/tb_lehmer_keyed_char_rotation_cipher_unit.sv
